### rtl/core/kda_pkg.sv
package kda_pkg;

  // Key count and raw level width
  localparam int NUM_KEYS   = 4;
  localparam int LEVEL_BITS = 4;
  // Slots cover both the lanes and the level bits
  localparam int SLOT_W     = (NUM_KEYS > LEVEL_BITS) ? NUM_KEYS : LEVEL_BITS;
  // Keys that see a raw level and can report events
  localparam int VIS_KEYS   = (NUM_KEYS < LEVEL_BITS) ? NUM_KEYS : LEVEL_BITS;

  localparam int TIME_W   = 32;
  localparam int THR_W    = 8;
  localparam int PERIOD_W = 16;
  localparam int EVENT_W  = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register reset values
  localparam logic [THR_W-1:0]      RST_THRESHOLD   = 8'd3;
  localparam logic [PERIOD_W-1:0]   RST_SCAN_PERIOD = 16'd10;
  localparam logic [PERIOD_W-1:0]   RST_LONG_DELAY  = 16'd500;
  localparam logic [PERIOD_W-1:0]   RST_REP_IVL     = 16'd100;
  localparam logic [LEVEL_BITS-1:0] RST_REP_MASK    = 4'd3;

  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_THRESHOLD = 3'd0,
    REG_SCAN_PERIOD        = 3'd1,
    REG_LONG_PRESS_DELAY   = 3'd2,
    REG_REPEAT_INTERVAL    = 3'd3,
    REG_REPEAT_ENABLE_MASK = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [LEVEL_BITS-1:0] key_levels;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]    event_key;
    logic                  auto_rep;
    logic [LEVEL_BITS-1:0] pressed_mask;
  } out_item_t;

  // Per-lane control from the top
  typedef struct packed {
    logic                sample;
    logic                raw;
    logic                clr_pend;
    logic                rep_en;
    logic [THR_W-1:0]    threshold;
    logic [PERIOD_W-1:0] delay;
    logic [TIME_W-1:0]   time_now;
  } lane_ctl_t;

  // Per-lane status toward the merge stage
  typedef struct packed {
    logic pending;
    logic rep_armed;
    logic press_due;
  } lane_status_t;

  // Merge stage verdict
  typedef struct packed {
    logic [EVENT_W-1:0] event_key;
    logic               auto_rep;
    logic               repeat_fire;
    logic [SLOT_W-1:0]  clr;
  } merge_res_t;

endpackage

### rtl/core/kda_lane.sv
module kda_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kda_pkg::lane_ctl_t    ctl,
  output kda_pkg::lane_status_t status,
  output logic                  stable_nxt
);

  logic                         stable_r;
  logic                         pend_r, pend_nxt;
  logic [kda_pkg::THR_W-1:0]    run_r, run_nxt, run_inc;
  logic [kda_pkg::TIME_W-1:0]   press_time_r;
  logic [kda_pkg::TIME_W-1:0]   held_time;
  logic                         flip;

  // Debounce run counter and state flip
  always_comb begin
    run_inc    = run_r + 1'b1;
    flip       = 1'b0;
    stable_nxt = stable_r;
    run_nxt    = run_r;
    pend_nxt   = pend_r & ~ctl.clr_pend;
    if (ctl.sample) begin
      if (ctl.raw == stable_r) begin
        run_nxt = '0;
      end else if (run_inc >= ctl.threshold) begin
        flip       = 1'b1;
        stable_nxt = ctl.raw;
        run_nxt    = '0;
        if (ctl.raw) begin
          pend_nxt = 1'b1;
        end
      end else begin
        run_nxt = run_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      run_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      stable_r <= stable_nxt;
      run_r    <= run_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Press time stamp, only read while the key is held
  always_ff @(posedge clk) begin
    if (flip && ctl.raw) begin
      press_time_r <= ctl.time_now;
    end
  end

  // Hold time check for auto-repeat
  assign held_time        = ctl.time_now - press_time_r;
  assign status.pending   = pend_r;
  assign status.rep_armed = stable_r & ctl.rep_en;
  assign status.press_due = held_time >= {{(kda_pkg::TIME_W-kda_pkg::PERIOD_W){1'b0}}, ctl.delay};

endmodule

### rtl/core/kda_merge.sv
module kda_merge (
  input  kda_pkg::lane_status_t status [kda_pkg::SLOT_W],
  input  logic                  interval_due,
  output kda_pkg::merge_res_t   res
);

  logic found_pend;
  logic found_rep;

  // Lowest pending key wins; else first armed key may repeat
  always_comb begin
    res        = '0;
    found_pend = 1'b0;
    found_rep  = 1'b0;
    for (int i = 0; i < kda_pkg::VIS_KEYS; i++) begin
      if (!found_pend && status[i].pending) begin
        found_pend    = 1'b1;
        res.clr[i]    = 1'b1;
        res.event_key = kda_pkg::EVENT_W'(i + 1);
      end
    end
    if (!found_pend) begin
      for (int i = 0; i < kda_pkg::VIS_KEYS; i++) begin
        if (!found_rep && status[i].rep_armed) begin
          found_rep = 1'b1;
          if (status[i].press_due && interval_due) begin
            res.event_key   = kda_pkg::EVENT_W'(i + 1);
            res.auto_rep    = 1'b1;
            res.repeat_fire = 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/core/key_debounce_autorepeat_unit.sv
// A result beat appears in the cycle after its item is accepted. Throughput:
// one item per cycle while not stalled; each key has its own lane and a merge
// stage picks the event in the accept cycle; one output register follows it.
// Reset (rst_n low, synchronous): time counters, key states, run counters and
// pending bits clear, registers return to their defaults, no result is held.
module key_debounce_autorepeat_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  kda_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output kda_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [kda_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [kda_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [kda_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  // Configuration registers
  logic [kda_pkg::THR_W-1:0]      threshold_r;
  logic [kda_pkg::PERIOD_W-1:0]   scan_period_r;
  logic [kda_pkg::PERIOD_W-1:0]   long_delay_r;
  logic [kda_pkg::PERIOD_W-1:0]   rep_ivl_r;
  logic [kda_pkg::LEVEL_BITS-1:0] rep_mask_r;
  logic                           cfg_wr;
  kda_pkg::cfg_reg_t              cfg_sel;

  // Timing state
  logic [kda_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [kda_pkg::TIME_W-1:0] last_scan_r;
  logic [kda_pkg::TIME_W-1:0] last_rep_r;
  logic [kda_pkg::TIME_W-1:0] scan_gap, rep_gap;

  logic accept, is_tick, is_poll, sample, interval_due;

  kda_pkg::lane_ctl_t    lane_ctl    [kda_pkg::SLOT_W];
  kda_pkg::lane_status_t lane_status [kda_pkg::SLOT_W];
  logic [kda_pkg::SLOT_W-1:0] stable_nxt;
  kda_pkg::merge_res_t   merge_res;

  logic                out_valid_r;
  kda_pkg::out_item_t  out_data_r, out_data_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = kda_pkg::cfg_reg_t'(cfg_paddr[kda_pkg::ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= kda_pkg::RST_THRESHOLD;
      scan_period_r <= kda_pkg::RST_SCAN_PERIOD;
      long_delay_r  <= kda_pkg::RST_LONG_DELAY;
      rep_ivl_r     <= kda_pkg::RST_REP_IVL;
      rep_mask_r    <= kda_pkg::RST_REP_MASK;
    end else if (cfg_wr) begin
      case (cfg_sel)
        kda_pkg::REG_DEBOUNCE_THRESHOLD: threshold_r   <= cfg_pwdata[kda_pkg::THR_W-1:0];
        kda_pkg::REG_SCAN_PERIOD:        scan_period_r <= cfg_pwdata[kda_pkg::PERIOD_W-1:0];
        kda_pkg::REG_LONG_PRESS_DELAY:   long_delay_r  <= cfg_pwdata[kda_pkg::PERIOD_W-1:0];
        kda_pkg::REG_REPEAT_INTERVAL:    rep_ivl_r     <= cfg_pwdata[kda_pkg::PERIOD_W-1:0];
        kda_pkg::REG_REPEAT_ENABLE_MASK: rep_mask_r    <= cfg_pwdata[kda_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_sel)
      kda_pkg::REG_DEBOUNCE_THRESHOLD: cfg_prdata = kda_pkg::DATA_W'(threshold_r);
      kda_pkg::REG_SCAN_PERIOD:        cfg_prdata = kda_pkg::DATA_W'(scan_period_r);
      kda_pkg::REG_LONG_PRESS_DELAY:   cfg_prdata = kda_pkg::DATA_W'(long_delay_r);
      kda_pkg::REG_REPEAT_INTERVAL:    cfg_prdata = kda_pkg::DATA_W'(rep_ivl_r);
      kda_pkg::REG_REPEAT_ENABLE_MASK: cfg_prdata = kda_pkg::DATA_W'(rep_mask_r);
      default:                         cfg_prdata = '0;
    endcase
  end

  // Handshake: output register frees or drains in the same cycle
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;
  assign is_tick  = in_data.operation == kda_pkg::OP_TICK;
  assign is_poll  = in_data.operation == kda_pkg::OP_POLL;

  // Millisecond clock and scan decision
  assign time_nxt     = (accept && is_tick) ? time_r + 1'b1 : time_r;
  assign scan_gap     = time_nxt - last_scan_r;
  assign sample       = accept & is_tick &
                        (scan_gap >= kda_pkg::TIME_W'(scan_period_r));
  assign rep_gap      = time_r - last_rep_r;
  assign interval_due = rep_gap >= kda_pkg::TIME_W'(rep_ivl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      last_scan_r <= '0;
      last_rep_r  <= '0;
    end else begin
      time_r <= time_nxt;
      if (sample) begin
        last_scan_r <= time_nxt;
      end
      if (accept && is_poll && merge_res.repeat_fire) begin
        last_rep_r <= time_r;
      end
    end
  end

  // Key lanes
  for (genvar i = 0; i < kda_pkg::SLOT_W; i++) begin : g_lane
    if (i < kda_pkg::NUM_KEYS) begin : g_key
      always_comb begin
        lane_ctl[i].sample    = sample;
        lane_ctl[i].clr_pend  = accept & is_poll & merge_res.clr[i];
        lane_ctl[i].threshold = threshold_r;
        lane_ctl[i].delay     = long_delay_r;
        lane_ctl[i].time_now  = time_nxt;
        if (i < kda_pkg::LEVEL_BITS) begin
          lane_ctl[i].raw    = in_data.key_levels[i % kda_pkg::LEVEL_BITS];
          lane_ctl[i].rep_en = rep_mask_r[i % kda_pkg::LEVEL_BITS];
        end else begin
          lane_ctl[i].raw    = 1'b0;
          lane_ctl[i].rep_en = 1'b0;
        end
      end

      kda_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl[i]),
        .status     (lane_status[i]),
        .stable_nxt (stable_nxt[i])
      );
    end else begin : g_pad
      assign lane_ctl[i]    = '0;
      assign lane_status[i] = '0;
      assign stable_nxt[i]  = 1'b0;
    end
  end

  // Event selection across lanes
  kda_merge u_merge (
    .status       (lane_status),
    .interval_due (interval_due),
    .res          (merge_res)
  );

  // Result beat
  always_comb begin
    out_data_nxt.pressed_mask = stable_nxt[kda_pkg::LEVEL_BITS-1:0];
    if (is_poll) begin
      out_data_nxt.event_key = merge_res.event_key;
      out_data_nxt.auto_rep  = merge_res.auto_rep;
    end else begin
      out_data_nxt.event_key = kda_pkg::EV_NONE;
      out_data_nxt.auto_rep  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/kda_checker.sv
module kda_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input kda_pkg::in_item_t          in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input kda_pkg::out_item_t         out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every accepted item yields a beat next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result beat after accepted item");

  // A tick never reports an event
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == kda_pkg::OP_TICK
    |=> out_data.event_key == kda_pkg::EV_NONE && !out_data.auto_rep)
    else $error("tick produced a key event");

  // A repeat names a key that is held
  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auto_rep
    |-> out_data.event_key != kda_pkg::EV_NONE &&
        ((out_data.pressed_mask >> (out_data.event_key - 3'd1)) & 4'd1) != 4'd0)
    else $error("repeat event for a released key");

endmodule

bind key_debounce_autorepeat_unit kda_checker u_kda_checker (.*);
